>>> src/fcsf_pkg.sv
package fcsf_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int MAX_PROBES    = 8;
  localparam int COORD_BITS    = 12;

  localparam int IdxW      = $clog2(TABLE_ENTRIES);
  localparam int CntW      = $clog2(MAX_PROBES + 1);
  localparam int EpochW    = 8;
  localparam int ColorW    = 24;
  localparam int CoordW    = 12;
  localparam int FirstW    = 12;
  localparam int EndW      = 13;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 13;
  localparam int QueueDepth = 2;

  localparam logic [31:0] HashMul = 32'h9E3779B1;
  localparam logic [EpochW-1:0] EpochMax = '1;
  localparam logic [CoordW-1:0] CoordMask =
    (COORD_BITS >= CoordW) ? {CoordW{1'b1}} : CoordW'((1 << COORD_BITS) - 1);

  localparam logic [CfgIdxW-1:0] CFG_BAND_FIRST = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_BAND_END   = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LEARN,
    KIND_MATCH
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_START,
    BK_PROBE
  } back_state_e;

  typedef struct packed {
    logic              frame_start;
    kind_e             kind;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ColorW-1:0] color;
    logic [IdxW-1:0]   home;
  } cmd_t;

  typedef struct packed {
    logic [EpochW-1:0] epoch;
    logic [ColorW-1:0] key;
  } entry_t;

endpackage

>>> src/fcsf_in_if.sv
interface fcsf_in_if;
  logic        valid;
  logic        ready;
  logic        frame_start;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (output valid, frame_start, pixel_x, pixel_y, red, green, blue,
                  input ready);
  modport sink   (input valid, frame_start, pixel_x, pixel_y, red, green, blue,
                  output ready);
endinterface

>>> src/fcsf_out_if.sv
interface fcsf_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] floor_x;
  logic [11:0] floor_y;
  logic        from_band;
  logic        set_overflow;

  modport source (output valid, floor_x, floor_y, from_band, set_overflow,
                  input ready);
  modport sink   (input valid, floor_x, floor_y, from_band, set_overflow,
                  output ready);
endinterface

>>> src/floor_color_set_filter_top.sv
// Floor color filter. Non-black pixels in rows [band_first_row, band_end_row)
// are reported as floor and their colors learned into a 1024-entry hashed set
// (linear probing, at most 8 slots); non-black pixels above the band are
// reported only if their color is already in the set, and band rows must come
// first. A front stage classifies and hashes each pixel and hands it through a
// two-entry queue to the table engine, which reads one slot per cycle from the
// table: it takes a pixel in the idle state, reads its home slot in the start
// state and probes on to a hit, the last slot or, when learning, a free slot.
// Black or below-band pixels without frame_start are dropped in the front at
// one per cycle while no front item waits for the queue. The engine takes a
// new pixel only when its result register is empty. frame_start clears
// the set by advancing an 8-bit epoch; after reset, and on every 255th
// frame_start, a sweep rewrites all 1024 table entries, during which no pixel
// is processed. The overflow flag is sticky until reset. Configuration must
// be written by the user only while idle; the block does not enforce it.
module floor_color_set_filter_top
  import fcsf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fcsf_in_if.sink             pixel_i,
  fcsf_out_if.source          floor_o
);

  logic push_valid, push_ready, pop_valid, pop;
  cmd_t push_cmd, pop_cmd;

  fcsf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_i      (pixel_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  fcsf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_i        (pop)
  );

  fcsf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_cmd_i   (pop_cmd),
    .pop_o     (pop),
    .floor_o   (floor_o)
  );

endmodule

>>> src/fcsf_front.sv
module fcsf_front
  import fcsf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fcsf_in_if.sink             pixel_i,
  output logic                push_valid_o,
  output cmd_t                push_cmd_o,
  input  logic                push_ready_i
);

  logic [FirstW-1:0] first_q;
  logic [EndW-1:0]   end_q;
  logic              s1_valid_q, s1_valid_d;
  cmd_t              s1_q, s1_d;
  logic              accept, push, keep;
  logic [CoordW-1:0] x_m, y_m;
  logic [ColorW-1:0] color;
  logic [31:0]       prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      end_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BAND_FIRST: first_q <= cfg_data_i[FirstW-1:0];
        CFG_BAND_END:   end_q   <= cfg_data_i[EndW-1:0];
        default: ;
      endcase
    end
  end

  assign push          = s1_valid_q && push_ready_i;
  assign accept        = pixel_i.valid && pixel_i.ready;
  assign pixel_i.ready = !s1_valid_q || push;

  always_comb begin
    x_m   = pixel_i.pixel_x & CoordMask;
    y_m   = pixel_i.pixel_y & CoordMask;
    color = {pixel_i.red, pixel_i.green, pixel_i.blue};
    s1_d  = s1_q;
    s1_d.frame_start = pixel_i.frame_start;
    s1_d.x     = x_m;
    s1_d.y     = y_m;
    s1_d.color = color;
    s1_d.home  = '0;
    if (color == '0) begin
      s1_d.kind = KIND_NONE;
    end else if ({1'b0, y_m} >= {1'b0, first_q} && {1'b0, y_m} < end_q) begin
      s1_d.kind = KIND_LEARN;
    end else if ({1'b0, y_m} < {1'b0, first_q}) begin
      s1_d.kind = KIND_MATCH;
    end else begin
      s1_d.kind = KIND_NONE;
    end
    // Items that neither clear nor can produce a result are dropped here.
    keep = pixel_i.frame_start || (s1_d.kind != KIND_NONE);
    if (accept) begin
      s1_valid_d = keep;
    end else if (push) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign prod = 32'({8'd0, s1_q.color} * HashMul);

  always_comb begin
    push_cmd_o      = s1_q;
    push_cmd_o.home = prod[8 +: IdxW];
  end
  assign push_valid_o = s1_valid_q;

endmodule

>>> src/fcsf_queue.sv
module fcsf_queue
  import fcsf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_i
);

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t                 mem_q [QueueDepth];
  logic [PtrW-1:0]      wr_q, rd_q;
  logic [PtrW:0]        fill_q;
  logic                 do_push, do_pop;

  assign push_ready_o = fill_q != (PtrW+1)'(QueueDepth);
  assign pop_valid_o  = fill_q != '0;
  assign pop_cmd_o    = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

>>> src/fcsf_back.sv
module fcsf_back
  import fcsf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       pop_o,
  fcsf_out_if.source floor_o
);

  back_state_e       state_q, state_d;
  cmd_t              item_q, item_d;
  logic [EpochW-1:0] epoch_q, epoch_d;
  logic [IdxW-1:0]   slot_q, slot_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   clr_q, clr_d;
  logic              loaded_q, loaded_d;
  logic              ovf_q, ovf_d;

  logic              out_valid_q, out_valid_d;
  logic [CoordW-1:0] out_x_q, out_y_q;
  logic              out_band_q, out_ovf_q, out_load;

  entry_t            mem [TABLE_ENTRIES];
  entry_t            rd_q, wr_data;
  logic              mem_we;
  logic [IdxW-1:0]   wr_addr, rd_addr;

  logic              hit, valid_e, last, learn, done, result, ovf_now;

  assign learn   = item_q.kind == KIND_LEARN;
  assign valid_e = rd_q.epoch == epoch_q;
  assign hit     = valid_e && (rd_q.key == item_q.color);
  assign last    = cnt_q == CntW'(MAX_PROBES - 1);
  assign done    = learn ? (!valid_e || hit || last) : (hit || last);
  assign result  = done && (learn || hit);
  assign ovf_now = learn && valid_e && !hit && last;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          state_d = (q_cmd_i.frame_start && epoch_q == EpochMax) ? BK_CLEAR : BK_START;
        end
      end
      BK_CLEAR: begin
        if (clr_q == '1) begin
          state_d = loaded_q ? BK_START : BK_IDLE;
        end
      end
      BK_START: begin
        state_d = (item_q.kind == KIND_NONE) ? BK_IDLE : BK_PROBE;
      end
      BK_PROBE: begin
        if (done) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    pop_o    = 1'b0;
    item_d   = item_q;
    epoch_d  = epoch_q;
    slot_d   = slot_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    loaded_d = loaded_q;
    ovf_d    = ovf_q;
    mem_we   = 1'b0;
    wr_addr  = slot_q;
    wr_data  = '{epoch: epoch_q, key: item_q.color};
    rd_addr  = slot_q;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          pop_o    = 1'b1;
          item_d   = q_cmd_i;
          loaded_d = 1'b1;
          // A new epoch invalidates every entry at once; a sweep handles wrap.
          if (q_cmd_i.frame_start && epoch_q != EpochMax) begin
            epoch_d = epoch_q + 1'b1;
          end
        end
      end
      BK_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_q;
        wr_data = '{epoch: '0, key: '0};
        clr_d   = clr_q + 1'b1;
        if (clr_q == '1) begin
          epoch_d = EpochW'(1);
        end
      end
      BK_START: begin
        loaded_d = 1'b0;
        rd_addr  = item_q.home;
        slot_d   = item_q.home;
        cnt_d    = '0;
      end
      BK_PROBE: begin
        if (learn && !valid_e) begin
          mem_we = 1'b1;
        end
        if (ovf_now) begin
          ovf_d = 1'b1;
        end
        if (done) begin
          out_load = result;
        end else begin
          rd_addr = slot_q + 1'b1;
          slot_d  = slot_q + 1'b1;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (floor_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      epoch_q     <= EpochW'(1);
      clr_q       <= '0;
      loaded_q    <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      clr_q       <= clr_d;
      loaded_q    <= loaded_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    slot_q <= slot_d;
    if (out_load) begin
      out_x_q    <= item_q.x;
      out_y_q    <= item_q.y;
      out_band_q <= learn;
      out_ovf_q  <= ovf_q | ovf_now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign floor_o.valid        = out_valid_q;
  assign floor_o.floor_x      = out_x_q;
  assign floor_o.floor_y      = out_y_q;
  assign floor_o.from_band    = out_band_q;
  assign floor_o.set_overflow = out_ovf_q;

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == BK_CLEAR || state_q == BK_PROBE))
    else $error("table written outside clear or probe");
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_PROBE |-> cnt_q < CntW'(MAX_PROBES))
    else $error("probe count past limit");
  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !out_valid_q && state_q == BK_IDLE)
    else $error("item taken while a result is pending");
  a_clear_epoch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CLEAR && state_d != BK_CLEAR) |=> epoch_q == EpochW'(1))
    else $error("epoch not restarted after sweep");
  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("current epoch equals the cleared mark");

endmodule
